FILE: rtl/core/smd_pkg.sv
package smd_pkg;

   localparam int PIXEL_W     = 8;
   localparam int ADDR_W      = 17;
   localparam int AMP_W       = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;

   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [ADDR_W-1:0]      address_type;
   typedef logic [AMP_W-1:0]       amp_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_AMPLIFICATION = 2'd0;
   localparam csr_index_type CSR_V_MIN         = 2'd1;
   localparam csr_index_type CSR_V_MAX         = 2'd2;

   localparam amp_type   AMP_RESET   = 4'd2;
   localparam pixel_type V_MIN_RESET = 8'd1;
   localparam pixel_type V_MAX_RESET = 8'd254;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_INIT   = 1'b1;

   typedef struct packed {
      logic      mode;
      pixel_type pixel;
   } beat_type;

   typedef struct packed {
      pixel_type mean;
      pixel_type variance;
   } cell_type;

endpackage

FILE: rtl/core/sigma_delta_motion_detect_top.sv
// A result passes stages a and b (address reduce), stage s3 and the output register.
// One beat per cycle unless stalled; the simple dual-port frame store does one read
// and one write-back per cycle, forwarding between back-to-back beats to one pixel.
// Reset clears the pipeline and output valids and loads the CSR defaults
// (amplification 2, v_min 1, v_max 254); the frame store is not cleared.
module sigma_delta_motion_detect_top #(
   parameter int PIXELS = 131072
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  smd_pkg::address_type   req_pixel_address,
   input  smd_pkg::pixel_type     req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_foreground,
   output smd_pkg::pixel_type     rsp_difference,
   input  logic                   csr_wr_en,
   input  smd_pkg::csr_index_type csr_index,
   input  smd_pkg::csr_data_type  csr_wr_data
);
   import smd_pkg::*;

   localparam int AW = $clog2(PIXELS);
   localparam int TW = AMP_W + PIXEL_W;

   typedef struct packed {
      logic      foreground;
      pixel_type difference;
   } result_type;

   amp_type        amp_ff;
   pixel_type      v_min_ff;
   pixel_type      v_max_ff;

   logic           advance;
   beat_type       req_beat;
   logic           s2_valid;
   beat_type       s2_beat;
   logic [AW-1:0]  s2_index;

   logic           s3_valid_ff;
   beat_type       s3_beat_ff;
   logic [AW-1:0]  s3_index_ff;
   cell_type       rd_cell_ff;
   logic           fwd_hit_ff;
   cell_type       fwd_cell_ff;

   cell_type       mem [PIXELS];

   cell_type       cur_cell;
   cell_type       wr_cell;
   result_type     result;
   pixel_type      mean_new;
   pixel_type      diff;
   logic [TW-1:0]  target;
   logic [PIXEL_W:0] var_step;
   logic [PIXEL_W:0] var_hi;
   logic [PIXEL_W:0] var_lo;

   logic           rsp_valid_ff;
   result_type     rsp_ff;
   logic           skid_valid_ff;
   result_type     skid_ff;
   logic           rsp_pop;
   logic           produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= AMP_RESET;
         v_min_ff <= V_MIN_RESET;
         v_max_ff <= V_MAX_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AMPLIFICATION: amp_ff   <= csr_wr_data[AMP_W-1:0];
            CSR_V_MIN:         v_min_ff <= csr_wr_data;
            CSR_V_MAX:         v_max_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign req_beat  = '{mode: req_mode, pixel: req_pixel};

   smd_addr_reduce #(
      .PIXELS (PIXELS)
   ) u_addr_reduce (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_beat    (req_beat),
      .in_address (req_pixel_address),
      .out_valid  (s2_valid),
      .out_beat   (s2_beat),
      .out_index  (s2_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_beat_ff  <= s2_beat;
         s3_index_ff <= s2_index;
         fwd_hit_ff  <= s3_valid_ff && (s2_index == s3_index_ff);
         fwd_cell_ff <= wr_cell;
      end
   end

   // read next pixel state, write back the current one
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_cell_ff <= mem[s2_index];
         if (s3_valid_ff) begin
            mem[s3_index_ff] <= wr_cell;
         end
      end
   end

   assign cur_cell = fwd_hit_ff ? fwd_cell_ff : rd_cell_ff;

   always_comb begin
      if (cur_cell.mean < s3_beat_ff.pixel) begin
         mean_new = cur_cell.mean + 8'd1;
      end else if (cur_cell.mean > s3_beat_ff.pixel) begin
         mean_new = cur_cell.mean - 8'd1;
      end else begin
         mean_new = cur_cell.mean;
      end

      diff   = (mean_new > s3_beat_ff.pixel) ? (mean_new - s3_beat_ff.pixel)
                                             : (s3_beat_ff.pixel - mean_new);
      target = TW'(amp_ff) * TW'(diff);

      if (TW'(cur_cell.variance) < target) begin
         var_step = {1'b0, cur_cell.variance} + 9'd1;
      end else if (TW'(cur_cell.variance) > target) begin
         var_step = {1'b0, cur_cell.variance} - 9'd1;
      end else begin
         var_step = {1'b0, cur_cell.variance};
      end

      var_hi = (var_step > {1'b0, v_max_ff}) ? {1'b0, v_max_ff} : var_step;
      var_lo = (var_hi < {1'b0, v_min_ff}) ? {1'b0, v_min_ff} : var_hi;

      if (s3_beat_ff.mode == MODE_INIT) begin
         wr_cell = '{mean: s3_beat_ff.pixel, variance: v_min_ff};
         result  = '{foreground: 1'b0, difference: '0};
      end else begin
         wr_cell = '{mean: mean_new, variance: var_lo[PIXEL_W-1:0]};
         result  = '{foreground: (diff >= var_lo[PIXEL_W-1:0]), difference: diff};
      end
   end

   assign rsp_pop = rsp_valid_ff && !rsp_stall;
   assign produce = s3_valid_ff && advance;

   // output register with skid: park a beat when the output is held
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               rsp_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (produce) begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_ff       <= result;
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_foreground = rsp_ff.foreground;
   assign rsp_difference = rsp_ff.difference;

endmodule

FILE: rtl/core/smd_addr_reduce.sv
module smd_addr_reduce #(
   parameter int PIXELS = 131072
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  smd_pkg::beat_type           in_beat,
   input  smd_pkg::address_type        in_address,
   output logic                        out_valid,
   output smd_pkg::beat_type           out_beat,
   output logic [$clog2(PIXELS)-1:0]   out_index
);
   import smd_pkg::*;

   localparam int AW    = $clog2(PIXELS);
   localparam int CW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
   localparam int SHIFT = 33;
   localparam int PW    = ADDR_W + 32;
   localparam int QW    = ADDR_W + CW;
   localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / PIXELS);

   logic              a_valid_ff;
   beat_type          a_beat_ff;
   address_type       a_addr_ff;
   address_type       a_quot_ff;
   address_type       a_quot_in;
   logic [PW-1:0]     quot_prod;

   logic              b_valid_ff;
   beat_type          b_beat_ff;
   logic [AW-1:0]     b_index_ff;
   logic [AW-1:0]     b_index_in;
   logic [QW-1:0]     part;
   logic [CW-1:0]     rem;
   logic [CW-1:0]     rem_fix;

   // estimate the quotient by reciprocal; it is exact or one short
   assign quot_prod = PW'(in_address) * PW'(RECIP);
   assign a_quot_in = ADDR_W'(quot_prod >> SHIFT);

   assign part       = QW'(a_quot_ff) * QW'(PIXELS);
   assign rem        = CW'(a_addr_ff) - CW'(part);
   assign rem_fix    = (rem >= CW'(PIXELS)) ? (rem - CW'(PIXELS)) : rem;
   assign b_index_in = rem_fix[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_beat_ff  <= in_beat;
         a_addr_ff  <= in_address;
         a_quot_ff  <= a_quot_in;
         b_beat_ff  <= a_beat_ff;
         b_index_ff <= b_index_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;
   assign out_index = b_index_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import smd_pkg::*;

   localparam int PIX        = 131072;
   localparam int CYCLE_LIMIT = 600000;
   localparam csr_index_type CSR_SPARE = 2'd3;

   typedef struct {
      logic        mode;
      address_type addr;
      pixel_type   pixel;
   } pixel_beat_type;

   typedef struct {
      logic      foreground;
      pixel_type difference;
   } verdict_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_mode = MODE_UPDATE;
   address_type   req_pixel_address = '0;
   pixel_type     req_pixel = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_foreground;
   pixel_type     rsp_difference;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_AMPLIFICATION;
   csr_data_type  csr_wr_data = '0;

   sigma_delta_motion_detect_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_pixel_address (req_pixel_address),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_foreground    (rsp_foreground),
      .rsp_difference    (rsp_difference),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // background model of the frame store
   pixel_type bg_mean     [PIX];
   pixel_type bg_variance [PIX];
   amp_type   amp_cfg  = AMP_RESET;
   pixel_type vmin_cfg = V_MIN_RESET;
   pixel_type vmax_cfg = V_MAX_RESET;

   pixel_beat_type pending_beats[$];
   verdict_type    expected_verdicts[$];
   int          errors = 0;
   int          results_seen = 0;
   int          cycles = 0;
   logic        req_taken = 1'b0;
   bit          feed_gaps = 1'b1;
   bit          drain_stalls = 1'b1;
   int          feed_wait = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   address_type addr_pool[$];
   pixel_type   pool_level[$];
   int          last_slot = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_variance(int v);
      if (v > int'(vmax_cfg)) v = int'(vmax_cfg);
      if (v < int'(vmin_cfg)) v = int'(vmin_cfg);
      return v;
   endfunction

   function automatic verdict_type track_pixel(pixel_beat_type b);
      verdict_type vd;
      int       m;
      int       diff;
      int       target;
      int       v;
      int       a;
      a = int'(b.addr);
      if (b.mode == MODE_INIT) begin
         bg_mean[a]     = b.pixel;
         bg_variance[a] = pixel_type'(clamp_variance(int'(vmin_cfg)));
         vd.foreground  = 1'b0;
         vd.difference  = '0;
         return vd;
      end
      m = int'(bg_mean[a]);
      if (m < int'(b.pixel)) m++;
      else if (m > int'(b.pixel)) m--;
      bg_mean[a] = pixel_type'(m);
      diff = (m > int'(b.pixel)) ? m - int'(b.pixel) : int'(b.pixel) - m;
      target = int'(amp_cfg) * diff;
      v = int'(bg_variance[a]);
      if (v < target) v++;
      else if (v > target) v--;
      v = clamp_variance(v);
      bg_variance[a] = pixel_type'(v);
      vd.foreground = (diff >= v);
      vd.difference = pixel_type'(diff);
      return vd;
   endfunction

   // driver
   always @(negedge clock) begin
      pixel_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (feed_wait > 0) begin
            req_valid <= 1'b0;
            feed_wait <= feed_wait - 1;
         end else if (pending_beats.size() != 0) begin
            b = pending_beats.pop_front();
            req_valid         <= 1'b1;
            req_mode          <= b.mode;
            req_pixel_address <= b.addr;
            req_pixel         <= b.pixel;
            feed_wait         <= feed_gaps ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls, with one long hold-off to back up the pipeline
   always @(negedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 100) begin
         rsp_stall <= 1'b1;
         hold_left <= 80;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = drain_stalls ? pick_gap() : 0;
         rsp_stall  <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_beat_type b;
      verdict_type    want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         b.mode  = req_mode;
         b.addr  = req_pixel_address;
         b.pixel = req_pixel;
         expected_verdicts.push_back(track_pixel(b));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_verdicts.size() == 0) begin
            $error("result beat with nothing expected: foreground %0d difference %0d",
                   rsp_foreground, rsp_difference);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_foreground !== want.foreground) begin
               $error("foreground: expected %0d, got %0d", want.foreground, rsp_foreground);
               errors++;
            end
            if (rsp_difference !== want.difference) begin
               $error("difference: expected %0d, got %0d", want.difference, rsp_difference);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("sigma_delta_motion_detect_top test failed");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, csr_data_type data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_AMPLIFICATION: amp_cfg = data[AMP_W-1:0];
         CSR_V_MIN:         vmin_cfg = data;
         CSR_V_MAX:         vmax_cfg = data;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(csr_data_type amp, csr_data_type lo, csr_data_type hi);
      csr_write(CSR_AMPLIFICATION, amp);
      csr_write(CSR_V_MIN, lo);
      csr_write(CSR_V_MAX, hi);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_beat(logic mode, address_type addr, pixel_type px);
      pixel_beat_type b;
      b.mode  = mode;
      b.addr  = addr;
      b.pixel = px;
      pending_beats.push_back(b);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_beats.size() != 0 || expected_verdicts.size() != 0 ||
             (req_valid && !req_taken))
         @(negedge clock);
   endtask

   // mostly updates at known pixels, steady or jumping; some initializes, of fresh or known pixels
   task automatic queue_random(int n);
      int          r;
      int          k;
      address_type a;
      pixel_type   px;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (addr_pool.size() == 0 || r < 8) begin
            a  = address_type'($urandom_range(0, PIX - 1));
            px = pixel_type'($urandom_range(0, 255));
            queue_beat(MODE_INIT, a, px);
            if (addr_pool.size() < 24) begin
               addr_pool.push_back(a);
               pool_level.push_back(px);
            end else begin
               k = $urandom_range(0, 23);
               addr_pool[k]  = a;
               pool_level[k] = px;
            end
         end else if (r < 12) begin
            k  = $urandom_range(0, addr_pool.size() - 1);
            px = pixel_type'($urandom_range(0, 255));
            pool_level[k] = px;
            queue_beat(MODE_INIT, addr_pool[k], px);
         end else begin
            k = (r < 27 && last_slot < addr_pool.size()) ?
                last_slot : $urandom_range(0, addr_pool.size() - 1);
            last_slot = k;
            if ($urandom_range(0, 2) == 0) px = pixel_type'($urandom_range(0, 255));
            else px = pool_level[k] + pixel_type'($urandom_range(0, 4)) - 8'd2;
            queue_beat(MODE_UPDATE, addr_pool[k], px);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default thresholds: extremes of address and pixel, forwarding cases
      feed_gaps    = 1'b1;
      drain_stalls = 1'b1;
      queue_beat(MODE_INIT,   17'h00000, 8'd0);
      queue_beat(MODE_INIT,   17'h1FFFF, 8'd255);
      queue_beat(MODE_INIT,   17'h15555, 8'hAA);
      queue_beat(MODE_INIT,   17'h0AAAA, 8'h55);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd0);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd255);
      queue_beat(MODE_UPDATE, 17'h1FFFF, 8'd0);
      queue_beat(MODE_UPDATE, 17'h1FFFF, 8'd255);
      queue_beat(MODE_UPDATE, 17'h15555, 8'h55);
      queue_beat(MODE_UPDATE, 17'h0AAAA, 8'hAA);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd1);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd1);
      queue_beat(MODE_INIT,   17'h00000, 8'd128);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd128);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd0);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd0);
      queue_beat(MODE_UPDATE, 17'h00000, 8'd0);
      queue_beat(MODE_UPDATE, 17'h1FFFF, 8'd255);
      wait_drained();

      // drive variance into the top clamp with a flickering pixel
      set_thresholds(8'd8, 8'd0, 8'd255);
      feed_gaps = 1'b0;
      queue_beat(MODE_INIT, 17'h1F0F0, 8'd128);
      for (int i = 0; i < 280; i++)
         queue_beat(MODE_UPDATE, 17'h1F0F0, (i % 2) ? 8'd255 : 8'd0);
      for (int i = 0; i < 20; i++)
         queue_beat(MODE_UPDATE, 17'h1F0F0, 8'd128);
      wait_drained();

      // crossed clamps, zero gain, and an unmapped register
      csr_write(CSR_SPARE, 8'hFF);
      set_thresholds(8'd0, 8'd255, 8'd0);
      feed_gaps = 1'b1;
      queue_random(200);
      wait_drained();

      set_thresholds(8'd15, 8'd0, 8'd0);
      drain_stalls = 1'b0;
      queue_random(200);
      wait_drained();

      set_thresholds(8'hF1, 8'd0, 8'd255);
      drain_stalls = 1'b1;
      queue_random(200);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         set_thresholds(csr_data_type'($urandom_range(0, 255)),
                        csr_data_type'($urandom_range(0, 40)),
                        csr_data_type'($urandom_range(20, 255)));
         feed_gaps    = (p != 1);
         drain_stalls = (p != 3);
         queue_random(210);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("sigma_delta_motion_detect_top test passed");
      else
         $display("sigma_delta_motion_detect_top test failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/smd_pkg.sv
rtl/core/smd_addr_reduce.sv
rtl/core/sigma_delta_motion_detect_top.sv
tb/tb.sv
